@@ hdl/lgm_pkg.sv @@
package lgm_pkg;

  // word operation
  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_TEXT   = 2'd2,
    OP_END    = 2'd3
  } op_t;

  // pattern element kind
  typedef enum logic [1:0] {
    KIND_LIT   = 2'd0,
    KIND_ONE   = 2'd1,
    KIND_ANY   = 2'd2,
    KIND_EMPTY = 2'd3
  } kind_t;

  // utf-8 continuation byte is 10xxxxxx
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_VALUE = 8'h80;

  // broadcast from the top level to every cell
  typedef struct packed {
    logic       text;
    logic       restart;
    logic       append;
    logic       clear;
    logic       cont;
    logic       start;
    kind_t      kind;
    logic       bend;
    logic [7:0] data;
  } cell_ctl_t;

  // handed from one cell to its neighbor
  typedef struct packed {
    logic valid;
    logic last;
  } cell_lnk_t;

  // one result word
  typedef struct packed {
    logic matched;
    logic status;
  } result_t;

endpackage

@@ hdl/lgm_cell.sv @@
module lgm_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  lgm_pkg::cell_ctl_t ctl,
  input  lgm_pkg::cell_lnk_t prev_lnk,
  input  logic              next_valid,
  input  logic              clo_prev,
  input  logic              clo_self,
  output lgm_pkg::cell_lnk_t lnk,
  output logic              gen,
  output logic              prop,
  output logic              hit,
  output logic              act,
  output logic              cip
);

  lgm_pkg::kind_t kind_r;
  logic           bend_r;
  logic [7:0]     byte_r;
  logic           valid_r, valid_nxt;
  logic           act_r, act_nxt;
  logic           cip_r, cip_nxt;

  logic boundary, pass, settled, reach, lit, pend, wr;

  // element local terms
  assign boundary = prev_lnk.last;
  assign pass     = (kind_r == lgm_pkg::KIND_ANY) || (kind_r == lgm_pkg::KIND_EMPTY);
  assign settled  = act_r | (cip_r & ~ctl.cont);
  assign reach    = boundary ? ctl.start : clo_prev;

  // carry terms for the closure scan
  assign gen  = valid_r & (settled | (boundary & ctl.start & pass));
  assign prop = valid_r & ~boundary & pass;

  // step terms
  assign lit  = (kind_r == lgm_pkg::KIND_LIT) & reach & (byte_r == ctl.data);
  assign pend = (ctl.cont & cip_r) | ((kind_r == lgm_pkg::KIND_ONE) & reach) |
                ((kind_r == lgm_pkg::KIND_ANY) & clo_self);

  // neighbor link and branch end
  assign lnk.valid = valid_r;
  assign lnk.last  = valid_r & (bend_r | ~next_valid);
  assign hit       = lnk.last & clo_self;
  assign act       = act_r;
  assign cip       = cip_r;

  // this cell takes the next appended element
  assign wr = ctl.append & prev_lnk.valid & ~valid_r;

  // next state
  always_comb begin
    valid_nxt = valid_r;
    act_nxt   = act_r;
    cip_nxt   = cip_r;
    if (ctl.clear) begin
      valid_nxt = 1'b0;
    end else if (wr) begin
      valid_nxt = 1'b1;
    end
    if (ctl.restart) begin
      act_nxt = 1'b0;
      cip_nxt = 1'b0;
    end else if (ctl.text) begin
      act_nxt = valid_r & lit;
      cip_nxt = valid_r & pend;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      act_r   <= 1'b0;
      cip_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      act_r   <= act_nxt;
      cip_r   <= cip_nxt;
    end
  end

  // element storage
  always_ff @(posedge clk) begin
    if (wr) begin
      kind_r <= ctl.kind;
      bend_r <= ctl.bend;
      byte_r <= ctl.data;
    end
  end

endmodule

@@ hdl/lgm_scan.sv @@
module lgm_scan #(
  parameter int N = 64
) (
  input  logic [N-1:0] gen,
  input  logic [N-1:0] prop,
  output logic [N-1:0] carry
);

  localparam int LVL = $clog2(N);

  logic [N-1:0] g_s [LVL+1];
  logic [N-1:0] p_s [LVL+1];

  assign g_s[0] = gen;
  assign p_s[0] = prop;

  // parallel prefix over (generate, propagate) pairs
  for (genvar lv = 0; lv < LVL; lv++) begin : g_lvl
    localparam int D = 1 << lv;
    for (genvar i = 0; i < N; i++) begin : g_bit
      if (i >= D) begin : g_comb
        assign g_s[lv+1][i] = g_s[lv][i] | (p_s[lv][i] & g_s[lv][i-D]);
        assign p_s[lv+1][i] = p_s[lv][i] & p_s[lv][i-D];
      end else begin : g_pass
        assign g_s[lv+1][i] = g_s[lv][i];
        assign p_s[lv+1][i] = p_s[lv][i];
      end
    end
  end

  assign carry = g_s[LVL];

endmodule

@@ hdl/lgm_outq.sv @@
module lgm_outq (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  lgm_pkg::result_t push_word,
  input  logic             out_stall,
  output logic             full,
  output logic             out_valid,
  output lgm_pkg::result_t out_word
);

  typedef enum logic [2:0] {
    Q_EMPTY = 3'b001,
    Q_ONE   = 3'b010,
    Q_FULL  = 3'b100
  } q_state_t;

  q_state_t         count_r, count_nxt;
  lgm_pkg::result_t e0_r, e0_nxt;
  lgm_pkg::result_t e1_r, e1_nxt;
  logic             pop;

  assign out_valid = (count_r != Q_EMPTY);
  assign out_word  = e0_r;
  assign full      = (count_r == Q_FULL);
  assign pop       = out_valid & ~out_stall;

  // two-entry queue, head in e0
  always_comb begin
    count_nxt = count_r;
    e0_nxt    = e0_r;
    e1_nxt    = e1_r;
    unique case (count_r)
      Q_EMPTY: begin
        if (push) begin
          e0_nxt    = push_word;
          count_nxt = Q_ONE;
        end
      end
      Q_ONE: begin
        if (push && pop) begin
          e0_nxt = push_word;
        end else if (push) begin
          e1_nxt    = push_word;
          count_nxt = Q_FULL;
        end else if (pop) begin
          count_nxt = Q_EMPTY;
        end
      end
      Q_FULL: begin
        if (pop) begin
          e0_nxt    = e1_r;
          count_nxt = Q_ONE;
        end
      end
      default: begin
        count_nxt = Q_EMPTY;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= Q_EMPTY;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e0_r <= e0_nxt;
    e1_r <= e1_nxt;
  end

endmodule

@@ hdl/like_glob_matcher.sv @@
// Whole-text LIKE matcher over OR-ed glob branches.
// Input channel (in_valid / in_stall) carries one word per item: clear the
// pattern, append one element, one text byte, or end of text. Every accepted
// word gives exactly one result word on the output channel (out_valid /
// out_stall): matched is set only on end of text, status flags an append
// dropped because all PATTERN_DEPTH elements are in use.
// cfg_we / cfg_wdata write utf8_mode (1 = UTF-8 code points, 0 = Latin-1);
// write it only while no word is in flight.
// Each pattern element lives in its own cell; a text byte updates all cells
// in the cycle it is accepted, with the run-closure across wildcard chains
// resolved by a log2(PATTERN_DEPTH)-level prefix network between the cells.
// Throughput is one word per cycle while in_stall is low. Results are
// registered in a two-entry output queue, so the input keeps flowing while
// one result waits; in_stall rises only when both entries are held by a
// stalled receiver.
// Reset (rst_n low, synchronous) empties the pattern and the queue, clears
// all active positions and sets utf8_mode to 1.
module like_glob_matcher #(
  parameter int PATTERN_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_opcode,
  input  logic [1:0] in_elem_kind,
  input  logic       in_elem_branch_end,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_matched,
  output logic       out_status,
  input  logic       cfg_we,
  input  logic       cfg_wdata
);

  localparam int N = PATTERN_DEPTH;

  lgm_pkg::op_t       op;
  lgm_pkg::cell_ctl_t ctl;
  lgm_pkg::cell_lnk_t lnk [N];
  lgm_pkg::result_t   res, out_word;
  logic               in_acc, q_full, start_r, start_nxt, utf8_r;
  logic [N-1:0]       gen, prop, carry, hit, vld, act, cip;

  assign op       = lgm_pkg::op_t'(in_opcode);
  assign in_stall = q_full;
  assign in_acc   = in_valid & ~in_stall;

  // broadcast control for this cycle's word
  always_comb begin
    ctl.text    = in_acc & (op == lgm_pkg::OP_TEXT);
    ctl.restart = in_acc & (op != lgm_pkg::OP_TEXT);
    ctl.append  = in_acc & (op == lgm_pkg::OP_APPEND);
    ctl.clear   = in_acc & (op == lgm_pkg::OP_CLEAR);
    ctl.cont    = ctl.text & utf8_r &
                  ((in_data_byte & lgm_pkg::CONT_MASK) == lgm_pkg::CONT_VALUE);
    ctl.start   = start_r;
    ctl.kind    = lgm_pkg::kind_t'(in_elem_kind);
    ctl.bend    = in_elem_branch_end;
    ctl.data    = in_data_byte;
  end

  // row of element cells
  for (genvar i = 0; i < N; i++) begin : g_cell
    lgm_pkg::cell_lnk_t prev_lnk;
    logic               next_valid, clo_prev;

    if (i == 0) begin : g_head
      assign prev_lnk = '{valid: 1'b1, last: 1'b1};
      assign clo_prev = 1'b0;
    end else begin : g_body
      assign prev_lnk = lnk[i-1];
      assign clo_prev = carry[i-1];
    end

    if (i == N - 1) begin : g_tail
      assign next_valid = 1'b0;
    end else begin : g_mid
      assign next_valid = lnk[i+1].valid;
    end

    lgm_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .prev_lnk   (prev_lnk),
      .next_valid (next_valid),
      .clo_prev   (clo_prev),
      .clo_self   (carry[i]),
      .lnk        (lnk[i]),
      .gen        (gen[i]),
      .prop       (prop[i]),
      .hit        (hit[i]),
      .act        (act[i]),
      .cip        (cip[i])
    );

    assign vld[i] = lnk[i].valid;
  end

  // closure across wildcard and empty runs
  lgm_scan #(.N(N)) u_scan (
    .gen   (gen),
    .prop  (prop),
    .carry (carry)
  );

  // result word
  assign res.matched = in_acc & (op == lgm_pkg::OP_END) & (|hit);
  assign res.status  = ctl.append & vld[N-1];

  lgm_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_acc),
    .push_word (res),
    .out_stall (out_stall),
    .full      (q_full),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  assign out_matched = out_word.matched;
  assign out_status  = out_word.status;

  // start-of-text flag
  always_comb begin
    start_nxt = start_r;
    if (ctl.text) begin
      start_nxt = 1'b0;
    end else if (ctl.restart) begin
      start_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= 1'b1;
      utf8_r  <= 1'b1;
    end else begin
      start_r <= start_nxt;
      if (cfg_we) begin
        utf8_r <= cfg_wdata;
      end
    end
  end

  // checks
  a_stall_has_backlog: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result waiting");

  a_store_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    ((vld >> 1) & ~vld) == '0)
    else $error("element cells not filled as a prefix");

  a_active_in_store: assert property (@(posedge clk) disable iff (!rst_n)
    ((act | cip) & ~vld) == '0)
    else $error("active position beyond the stored pattern");

  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.restart |=> (start_r && act == '0 && cip == '0))
    else $error("text not restarted after a non-text word");

endmodule
